>>> rtl/core/rdm_pkg.sv
// Shared types, constants and the helper function of the RTT delay monitor.
package rdm_pkg;

	// Field widths fixed by the interface.
	localparam int RTT_W     = 24;
	localparam int THR_W     = RTT_W + 2;
	localparam int CWND_W    = 20;
	localparam int BETA_W    = 10;
	localparam int FACTOR_W  = BETA_W + 1;
	localparam int PROD_W    = CWND_W + FACTOR_W;
	localparam int SCALE_SH  = 10;
	localparam int SCALED_W  = PROD_W - SCALE_SH;
	localparam int CREDIT_W  = 3;
	localparam int COUNT_W   = 32;
	localparam int PKTS_W    = 16;

	// Constants of the algorithm.
	localparam logic [BETA_W-1:0]   BETA_RESET  = 10'd717;
	localparam logic [FACTOR_W-1:0] BETA_OFFSET = 11'd100;
	localparam logic [CREDIT_W-1:0] CREDIT_MAX  = 3'd5;
	localparam logic [CWND_W-1:0]   CWND_MAX    = 20'hFFFFF;
	localparam logic [CWND_W-1:0]   CWND_FLOOR  = 20'd2;
	localparam logic [PKTS_W-1:0]   PKTS_ONE    = 16'd1;

	// Congestion avoidance state reported with every result.
	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_CAUTION = 2'd1,
		MODE_BACKOFF = 2'd2,
		MODE_BER     = 2'd3
	} mode_t;

	// Kind of work the front hands to the back.
	typedef enum logic [1:0] {
		KIND_NOP    = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_LOSS   = 2'd2
	} kind_t;

	// Classified item passed from the front to the back.
	typedef struct packed {
		kind_t                 kind;
		logic                  decide;
		logic                  ber;
		logic [CWND_W-1:0]     cwnd;
		logic [SCALED_W-1:0]   scaled;
		logic [RTT_W-1:0]      srtt;
		logic [RTT_W-1:0]      dev;
		logic [RTT_W-1:0]      high;
		logic [RTT_W-1:0]      low;
	} mid_t;

	// Finished result item.
	typedef struct packed {
		logic [CWND_W-1:0]     cwnd_out;
		logic                  cwnd_reduced;
		mode_t                 ca_state;
		logic [RTT_W-1:0]      rtt_average;
		logic [RTT_W-1:0]      rtt_spread;
		logic [THR_W-1:0]      delay_threshold;
		logic                  loss_was_bit_error;
		logic [COUNT_W-1:0]    bit_error_losses;
		logic [COUNT_W-1:0]    congestion_losses;
	} res_t;

	// Delay threshold: average plus three times the deviation.
	function automatic logic [THR_W-1:0] thresh(input logic [RTT_W-1:0] s,
			input logic [RTT_W-1:0] d);
		logic [THR_W-1:0] ds;
		ds = THR_W'(d);
		return THR_W'(s) + (ds << 1) + ds;
	endfunction

endpackage

>>> rtl/core/rdm_fifo.sv
// Small register queue used between the front, the back and the result port.
module rdm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/core/rdm_front.sv
// Front part: delay statistics, delayed-ACK credit, loss classification and window product.
module rdm_front import rdm_pkg::*; #(
	parameter int MIN_SAMPLES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                mode,
	input  logic [RTT_W-1:0]    rtt_us,
	input  logic [PKTS_W-1:0]   packets_acked,
	input  logic                no_sack_outstanding,
	input  logic [CWND_W-1:0]   cwnd,
	input  logic [BETA_W-1:0]   beta,
	output mid_t                rec
);

	localparam int SCNT_W = $clog2(MIN_SAMPLES + 1);
	localparam logic [SCNT_W-1:0] SCNT_SAT = SCNT_W'(MIN_SAMPLES);

	logic [RTT_W-1:0]    low_q, high_q, srtt_q, dev_q;
	logic [CREDIT_W-1:0] credit_q;
	logic [SCNT_W-1:0]   scnt_q;

	logic [RTT_W-1:0]    low_d, high_d, srtt_d, dev_d;
	logic [CREDIT_W-1:0] credit_d;
	logic [SCNT_W-1:0]   scnt_d;

	logic [RTT_W+2:0]    srtt_sum;
	logic [RTT_W-1:0]    srtt_new;
	logic [RTT_W-1:0]    diff;
	logic [RTT_W+1:0]    dev_sum;
	logic [RTT_W-1:0]    dev_new;
	logic [RTT_W-1:0]    low_min;
	logic [FACTOR_W-1:0] factor;
	logic [PROD_W-1:0]   prod;

	// Window product for a possible caution entry.
	assign factor = FACTOR_W'(beta) + BETA_OFFSET;
	assign prod   = PROD_W'(cwnd) * PROD_W'(factor);

	// Smoothed RTT with weight 1/8 and deviation with weight 1/4.
	always_comb begin
		srtt_sum = ({srtt_q, 3'b000} - {3'b000, srtt_q}) + {3'b000, rtt_us};
		srtt_new = (srtt_q == '0) ? rtt_us : srtt_sum[RTT_W+2:3];
		diff     = (rtt_us > srtt_new) ? (rtt_us - srtt_new) : (srtt_new - rtt_us);
		dev_sum  = ({dev_q, 1'b0} + {2'b00, dev_q}) + {2'b00, diff};
		dev_new  = (dev_q == '0) ? diff : dev_sum[RTT_W+1:2];
		low_min  = (rtt_us < low_q) ? rtt_us : low_q;
	end

	// Next statistics and the classified item.
	always_comb begin
		low_d    = low_q;
		high_d   = high_q;
		srtt_d   = srtt_q;
		dev_d    = dev_q;
		credit_d = credit_q;
		scnt_d   = scnt_q;

		rec.kind   = KIND_NOP;
		rec.decide = 1'b0;
		rec.ber    = 1'b0;
		rec.cwnd   = cwnd;
		rec.scaled = prod[PROD_W-1:SCALE_SH];

		if (mode) begin
			// Loss: classify against the statistics, then clear them.
			rec.kind = KIND_LOSS;
			rec.ber  = (scnt_q == SCNT_SAT) && (THR_W'(high_q) <= thresh(srtt_q, dev_q));
			low_d    = '1;
			high_d   = '0;
			srtt_d   = '0;
			dev_d    = '0;
			credit_d = '0;
			scnt_d   = '0;
		end else if (rtt_us != '0) begin
			if (no_sack_outstanding && packets_acked == PKTS_ONE && credit_q != '0) begin
				// Delayed ACK absorbed: only the minimum moves.
				low_d    = low_min;
				credit_d = credit_q - 1'b1;
			end else begin
				if (no_sack_outstanding && packets_acked > PKTS_ONE
						&& credit_q < CREDIT_MAX) begin
					credit_d = credit_q + 1'b1;
				end
				rec.kind = KIND_SAMPLE;
				low_d    = low_min;
				high_d   = (rtt_us > high_q) ? rtt_us : high_q;
				srtt_d   = srtt_new;
				dev_d    = dev_new;
				if (scnt_q < SCNT_SAT) begin
					scnt_d = scnt_q + 1'b1;
				end else begin
					rec.decide = 1'b1;
				end
			end
		end

		rec.srtt = srtt_d;
		rec.dev  = dev_d;
		rec.high = high_d;
		rec.low  = low_d;
	end

	// Statistics registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= '1;
			high_q   <= '0;
			srtt_q   <= '0;
			dev_q    <= '0;
			credit_q <= '0;
			scnt_q   <= '0;
		end else if (accept) begin
			low_q    <= low_d;
			high_q   <= high_d;
			srtt_q   <= srtt_d;
			dev_q    <= dev_d;
			credit_q <= credit_d;
			scnt_q   <= scnt_d;
		end
	end

endmodule

>>> rtl/core/rdm_back.sv
// Back part: mode decisions, window rescaling, loss counters and result assembly.
module rdm_back import rdm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  mid_t rec,
	output res_t res
);

	mode_t              mode_q, mode_d;
	logic [COUNT_W-1:0] ber_cnt_q, ber_cnt_d;
	logic [COUNT_W-1:0] cong_cnt_q, cong_cnt_d;
	logic [THR_W-1:0]   thr;
	logic [CWND_W-1:0]  cwnd_scaled;

	assign thr = thresh(rec.srtt, rec.dev);

	// Rescaled window with a floor and saturation.
	always_comb begin
		if (rec.scaled < SCALED_W'(CWND_FLOOR)) begin
			cwnd_scaled = CWND_FLOOR;
		end else if (rec.scaled > SCALED_W'(CWND_MAX)) begin
			cwnd_scaled = CWND_MAX;
		end else begin
			cwnd_scaled = rec.scaled[CWND_W-1:0];
		end
	end

	// Mode and counter update for one item.
	always_comb begin
		mode_d     = mode_q;
		ber_cnt_d  = ber_cnt_q;
		cong_cnt_d = cong_cnt_q;
		res.cwnd_out           = rec.cwnd;
		res.cwnd_reduced       = 1'b0;
		res.loss_was_bit_error = 1'b0;

		case (rec.kind)
			KIND_LOSS: begin
				if (rec.ber) begin
					mode_d    = MODE_BER;
					ber_cnt_d = ber_cnt_q + 1'b1;
					res.loss_was_bit_error = 1'b1;
				end else begin
					mode_d     = MODE_BACKOFF;
					cong_cnt_d = cong_cnt_q + 1'b1;
				end
			end
			KIND_SAMPLE: begin
				if (rec.decide) begin
					if (THR_W'(rec.high) > thr) begin
						if (mode_q == MODE_NORMAL) begin
							mode_d           = MODE_CAUTION;
							res.cwnd_out     = cwnd_scaled;
							res.cwnd_reduced = 1'b1;
						end
					end else if (rec.high <= rec.low) begin
						mode_d = MODE_NORMAL;
					end
				end
			end
			default: begin
			end
		endcase

		res.ca_state          = mode_d;
		res.rtt_average       = rec.srtt;
		res.rtt_spread        = rec.dev;
		res.delay_threshold   = thr;
		res.bit_error_losses  = ber_cnt_d;
		res.congestion_losses = cong_cnt_d;
	end

	// Mode and counters survive loss events.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			ber_cnt_q  <= '0;
			cong_cnt_q <= '0;
		end else if (take) begin
			mode_q     <= mode_d;
			ber_cnt_q  <= ber_cnt_d;
			cong_cnt_q <= cong_cnt_d;
		end
	end

endmodule

>>> rtl/core/rtt_delay_monitor_loss_classifier_top.sv
// Top level of the RTT delay monitor and loss classifier.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | push / full          | mode, rtt_us, packets_acked,
//           |                      | no_sack_outstanding, cwnd
//  result   | pop / empty          | cwnd_out, cwnd_reduced, ca_state, rtt_average,
//           |                      | rtt_spread, delay_threshold, loss_was_bit_error,
//           |                      | bit_error_losses, congestion_losses
//  config   | cfg_we               | cfg_wdata (beta)
//
// One item is accepted per cycle while full is low; the front updates the delay statistics in the
// cycle of acceptance, the back settles the mode when the item is taken from the queue between them.
// A result reaches the result ports through the queue between front and back and the result queue.
// Each side stalls on its own: full rises only when the queue between front and
// back is full, which happens only when results are not popped.
// Reset sets beta to 717, clears statistics, counters and mode, and empties queues.
module rtt_delay_monitor_loss_classifier_top import rdm_pkg::*; #(
	parameter int MIN_SAMPLES = 8,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	// Input items
	input  logic                push,
	output logic                full,
	input  logic                mode,
	input  logic [RTT_W-1:0]    rtt_us,
	input  logic [PKTS_W-1:0]   packets_acked,
	input  logic                no_sack_outstanding,
	input  logic [CWND_W-1:0]   cwnd,
	// Result items
	output logic                empty,
	input  logic                pop,
	output logic [CWND_W-1:0]   cwnd_out,
	output logic                cwnd_reduced,
	output logic [1:0]          ca_state,
	output logic [RTT_W-1:0]    rtt_average,
	output logic [RTT_W-1:0]    rtt_spread,
	output logic [THR_W-1:0]    delay_threshold,
	output logic                loss_was_bit_error,
	output logic [COUNT_W-1:0]  bit_error_losses,
	output logic [COUNT_W-1:0]  congestion_losses,
	// Configuration
	input  logic                cfg_we,
	input  logic [BETA_W-1:0]   cfg_wdata
);

	logic [BETA_W-1:0] beta_q;
	logic              in_accept;
	mid_t              front_rec;
	mid_t              mid_rec;
	logic              mid_empty;
	logic              mid_take;
	res_t              back_res;
	res_t              out_res;
	logic              out_full;

	// Beta register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_RESET;
		end else if (cfg_we) begin
			beta_q <= cfg_wdata;
		end
	end

	assign in_accept = push && !full;
	assign mid_take  = !mid_empty && !out_full;

	// Front: statistics and classification.
	rdm_front #(
		.MIN_SAMPLES(MIN_SAMPLES)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (in_accept),
		.mode               (mode),
		.rtt_us             (rtt_us),
		.packets_acked      (packets_acked),
		.no_sack_outstanding(no_sack_outstanding),
		.cwnd               (cwnd),
		.beta               (beta_q),
		.rec                (front_rec)
	);

	// Queue between front and back.
	rdm_fifo #(
		.WIDTH($bits(mid_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (in_accept),
		.wr_data(front_rec),
		.full   (full),
		.rd_en  (mid_take),
		.rd_data(mid_rec),
		.empty  (mid_empty)
	);

	// Back: mode, window and counters.
	rdm_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (mid_take),
		.rec   (mid_rec),
		.res   (back_res)
	);

	// Result queue.
	rdm_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mid_take),
		.wr_data(back_res),
		.full   (out_full),
		.rd_en  (pop && !empty),
		.rd_data(out_res),
		.empty  (empty)
	);

	// Result fields.
	assign cwnd_out           = out_res.cwnd_out;
	assign cwnd_reduced       = out_res.cwnd_reduced;
	assign ca_state           = out_res.ca_state;
	assign rtt_average        = out_res.rtt_average;
	assign rtt_spread         = out_res.rtt_spread;
	assign delay_threshold    = out_res.delay_threshold;
	assign loss_was_bit_error = out_res.loss_was_bit_error;
	assign bit_error_losses   = out_res.bit_error_losses;
	assign congestion_losses  = out_res.congestion_losses;

	// A rescaled window is only reported on caution entry and respects the floor.
	a_reduced_caution: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && cwnd_reduced) |-> (ca_state == MODE_CAUTION && cwnd_out >= CWND_FLOOR))
		else $error("rescaled window outside caution entry");

	// A bit error classification always leaves the block in the bit error state.
	a_ber_state: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && loss_was_bit_error) |-> (ca_state == MODE_BER))
		else $error("bit error loss without bit error state");

	// A loss taken by the back raises exactly one of the two counters.
	a_loss_count: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_take && mid_rec.kind == KIND_LOSS) |->
		((back_res.bit_error_losses + back_res.congestion_losses)
			== (u_back.ber_cnt_q + u_back.cong_cnt_q + 1'b1)))
		else $error("loss item did not advance the loss counters by one");

endmodule

>>> tb/rtt_delay_monitor_loss_classifier_top_tb.sv
// Self-checking testbench for the RTT delay monitor and loss classifier top level.
module rtt_delay_monitor_loss_classifier_top_tb;
	import rdm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MIN_SAMPLES = 8;

	// One input item as the sender offers it.
	typedef struct packed {
		logic               mode;
		logic [RTT_W-1:0]   rtt;
		logic [PKTS_W-1:0]  pkts;
		logic               no_sack;
		logic [CWND_W-1:0]  cwnd;
	} ack_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic               mode = 1'b0;
	logic [RTT_W-1:0]   rtt_us = '0;
	logic [PKTS_W-1:0]  packets_acked = '0;
	logic               no_sack_outstanding = 1'b0;
	logic [CWND_W-1:0]  cwnd = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [CWND_W-1:0]  cwnd_out;
	logic               cwnd_reduced;
	logic [1:0]         ca_state;
	logic [RTT_W-1:0]   rtt_average;
	logic [RTT_W-1:0]   rtt_spread;
	logic [THR_W-1:0]   delay_threshold;
	logic               loss_was_bit_error;
	logic [COUNT_W-1:0] bit_error_losses;
	logic [COUNT_W-1:0] congestion_losses;
	logic               cfg_we = 1'b0;
	logic [BETA_W-1:0]  cfg_wdata = BETA_RESET;

	rtt_delay_monitor_loss_classifier_top #(
		.MIN_SAMPLES(MIN_SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.rtt_us(rtt_us),
		.packets_acked(packets_acked),
		.no_sack_outstanding(no_sack_outstanding),
		.cwnd(cwnd),
		.empty(empty),
		.pop(pop),
		.cwnd_out(cwnd_out),
		.cwnd_reduced(cwnd_reduced),
		.ca_state(ca_state),
		.rtt_average(rtt_average),
		.rtt_spread(rtt_spread),
		.delay_threshold(delay_threshold),
		.loss_was_bit_error(loss_was_bit_error),
		.bit_error_losses(bit_error_losses),
		.congestion_losses(congestion_losses),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Estimator state mirrored by the testbench.
	logic [BETA_W-1:0]   est_beta = BETA_RESET;
	logic [RTT_W-1:0]    est_low = '1;
	logic [RTT_W-1:0]    est_high = '0;
	logic [CREDIT_W-1:0] est_credit = '0;
	int                  est_count = 0;
	logic [RTT_W-1:0]    est_srtt = '0;
	logic [RTT_W-1:0]    est_dev = '0;
	mode_t               est_mode = MODE_NORMAL;
	logic [COUNT_W-1:0]  est_ber_total = '0;
	logic [COUNT_W-1:0]  est_cong_total = '0;

	ack_item_t pending_acks[$];
	res_t      awaited_reports[$];
	int        errors = 0;
	bit        took_item = 1'b0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        rx_cycles = 0;
	int        rx_style = 0;
	int        hold_left = 0;
	bit        held_once = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Average plus three times the deviation, at the threshold width.
	function automatic logic [THR_W-1:0] delay_limit();
		return THR_W'(64'(est_srtt) + 3 * 64'(est_dev));
	endfunction

	// Advance the mirrored estimator by one item and return the report it should produce.
	function automatic res_t update_estimator(ack_item_t it);
		res_t             r;
		longint unsigned  scaled;
		logic [RTT_W-1:0] diff;
		bit               absorbed;
		r = '0;
		r.cwnd_out = it.cwnd;
		absorbed = 1'b0;
		if (it.mode) begin
			// Loss: classify on the statistics gathered so far, then clear them.
			if (est_count >= MIN_SAMPLES && est_high <= delay_limit()) begin
				est_mode = MODE_BER;
				est_ber_total++;
				r.loss_was_bit_error = 1'b1;
			end else begin
				est_mode = MODE_BACKOFF;
				est_cong_total++;
			end
			est_low = '1;
			est_high = '0;
			est_credit = '0;
			est_count = 0;
			est_srtt = '0;
			est_dev = '0;
		end else if (it.rtt != '0) begin
			// Delayed ACK credit handling.
			if (it.no_sack) begin
				if (it.pkts == PKTS_ONE && est_credit != '0) begin
					if (it.rtt < est_low)
						est_low = it.rtt;
					est_credit--;
					absorbed = 1'b1;
				end else if (it.pkts > PKTS_ONE && est_credit < CREDIT_MAX) begin
					est_credit++;
				end
			end
			if (!absorbed) begin
				if (it.rtt < est_low)
					est_low = it.rtt;
				if (it.rtt > est_high)
					est_high = it.rtt;
				// Smoothed RTT and deviation; a zero value is seeded directly.
				if (est_srtt == '0)
					est_srtt = it.rtt;
				else
					est_srtt = RTT_W'((64'(est_srtt) * 7 + 64'(it.rtt)) / 8);
				diff = (it.rtt > est_srtt) ? it.rtt - est_srtt : est_srtt - it.rtt;
				if (est_dev == '0)
					est_dev = diff;
				else
					est_dev = RTT_W'((64'(est_dev) * 3 + 64'(diff)) / 4);
				// Mode decision once warm-up is over.
				if (est_count < MIN_SAMPLES) begin
					est_count++;
				end else if (est_high > delay_limit()) begin
					if (est_mode == MODE_NORMAL) begin
						est_mode = MODE_CAUTION;
						scaled = 64'(it.cwnd) * (64'(est_beta) + 64'(BETA_OFFSET)) / 1024;
						if (scaled < 64'(CWND_FLOOR))
							scaled = 64'(CWND_FLOOR);
						if (scaled > 64'(CWND_MAX))
							scaled = 64'(CWND_MAX);
						r.cwnd_out = CWND_W'(scaled);
						r.cwnd_reduced = 1'b1;
					end
				end else if (est_high <= est_low) begin
					est_mode = MODE_NORMAL;
				end
			end
		end
		r.ca_state = est_mode;
		r.rtt_average = est_srtt;
		r.rtt_spread = est_dev;
		r.delay_threshold = delay_limit();
		r.bit_error_losses = est_ber_total;
		r.congestion_losses = est_cong_total;
		return r;
	endfunction

	// Accepted items feed the estimator; accepted reports are checked in order.
	always @(posedge clk) begin : report_check
		res_t e;
		took_item = arst_n && push && !full;
		if (took_item)
			awaited_reports.push_back(update_estimator({mode, rtt_us, packets_acked,
				no_sack_outstanding, cwnd}));
		if (arst_n && pop && !empty) begin
			if (awaited_reports.size() == 0) begin
				$error("report item arrived with none awaited");
				errors++;
			end else begin
				e = awaited_reports.pop_front();
				if (cwnd_out !== e.cwnd_out) begin
					$error("cwnd_out: expected %0d, got %0d", e.cwnd_out, cwnd_out);
					errors++;
				end
				if (cwnd_reduced !== e.cwnd_reduced) begin
					$error("cwnd_reduced: expected %0d, got %0d", e.cwnd_reduced, cwnd_reduced);
					errors++;
				end
				if (ca_state !== e.ca_state) begin
					$error("ca_state: expected %0d, got %0d", e.ca_state, ca_state);
					errors++;
				end
				if (rtt_average !== e.rtt_average) begin
					$error("rtt_average: expected %0d, got %0d", e.rtt_average, rtt_average);
					errors++;
				end
				if (rtt_spread !== e.rtt_spread) begin
					$error("rtt_spread: expected %0d, got %0d", e.rtt_spread, rtt_spread);
					errors++;
				end
				if (delay_threshold !== e.delay_threshold) begin
					$error("delay_threshold: expected %0d, got %0d", e.delay_threshold,
						delay_threshold);
					errors++;
				end
				if (loss_was_bit_error !== e.loss_was_bit_error) begin
					$error("loss_was_bit_error: expected %0d, got %0d", e.loss_was_bit_error,
						loss_was_bit_error);
					errors++;
				end
				if (bit_error_losses !== e.bit_error_losses) begin
					$error("bit_error_losses: expected %0d, got %0d", e.bit_error_losses,
						bit_error_losses);
					errors++;
				end
				if (congestion_losses !== e.congestion_losses) begin
					$error("congestion_losses: expected %0d, got %0d", e.congestion_losses,
						congestion_losses);
					errors++;
				end
			end
		end
	end

	// Sender: offers pending items in bursts with random gaps, holding each until taken.
	always @(negedge clk) begin : ack_sender
		ack_item_t cur;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !took_item) begin
			// The current item is still on offer.
		end else if (gap_left > 0) begin
			gap_left--;
			push <= 1'b0;
		end else if (pending_acks.size() != 0) begin
			cur = pending_acks.pop_front();
			mode <= cur.mode;
			rtt_us <= cur.rtt;
			packets_acked <= cur.pkts;
			no_sack_outstanding <= cur.no_sack;
			cwnd <= cur.cwnd;
			push <= 1'b1;
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 12);
				gap_left = $urandom_range(0, 6);
			end else begin
				burst_left--;
			end
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: stalls on its own pattern, with at least one long hold-off under load.
	always @(negedge clk) begin
		rx_cycles++;
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if ((!held_once && pending_acks.size() > 50) || $urandom_range(0, 399) == 0) begin
			held_once = 1'b1;
			hold_left = $urandom_range(40, 90);
			pop <= 1'b0;
		end else begin
			if (rx_cycles % 64 == 0)
				rx_style = $urandom_range(0, 3);
			case (rx_style)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= (rx_cycles % 4 == 0);
				default: pop <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic add_item(input logic m, input logic [RTT_W-1:0] r,
			input logic [PKTS_W-1:0] p, input logic ns, input logic [CWND_W-1:0] w);
		pending_acks.push_back({m, r, p, ns, w});
	endtask

	// ACK sample with random acked count, SACK flag and window.
	task automatic add_random_ack(input logic [RTT_W-1:0] r);
		logic [PKTS_W-1:0] p;
		logic [CWND_W-1:0] w;
		int                pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			p = PKTS_ONE;
		else if (pick < 7)
			p = PKTS_W'($urandom_range(2, 5));
		else if (pick < 9)
			p = PKTS_W'($urandom);
		else
			p = '0;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			w = CWND_W'($urandom_range(0, 30));
		else if (pick == 2)
			w = CWND_MAX - CWND_W'($urandom_range(0, 3));
		else
			w = CWND_W'($urandom);
		add_item(1'b0, r, p, 1'($urandom_range(0, 1)), w);
	endtask

	function automatic logic [RTT_W-1:0] clamp_rtt(longint unsigned v);
		return (v > 64'hFFFFFF) ? '1 : RTT_W'(v);
	endfunction

	// Random connection episodes: steady, spiky or drifting RTT runs, losses and noise.
	task automatic add_random_episodes(input int target);
		int          made;
		int          kind;
		int          n;
		int unsigned base;
		longint unsigned r;
		made = 0;
		while (made < target) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				// Noise: any field value, including no-sample ACKs and stray losses.
				r = ($urandom_range(0, 3) == 0) ? 0 : $urandom;
				n = ($urandom_range(0, 5) == 0);
				add_item(1'(n), RTT_W'(r), PKTS_W'($urandom), 1'($urandom),
					CWND_W'($urandom));
				if (n != 0 || RTT_W'(r) != '0)
					made++;
			end else begin
				base = $urandom_range(1, (1 << $urandom_range(1, 24)) - 1);
				n = $urandom_range(6, 14);
				for (int i = 0; i < n; i++) begin
					if (kind < 5)
						r = base;
					else if (kind < 8)
						r = (i == 0) ? 64'(base) * 4 + $urandom_range(0, 1000)
							: 64'(base) + $urandom_range(0, base / 8);
					else
						r = 64'(base) + $urandom_range(0, base);
					add_random_ack(clamp_rtt(r));
					made++;
				end
				if ($urandom_range(0, 1) == 0) begin
					add_item(1'b1, RTT_W'($urandom), PKTS_W'($urandom), 1'($urandom),
						CWND_W'($urandom));
					made++;
				end
			end
		end
	endtask

	// Beta is written only while the block is idle.
	task automatic write_beta(input logic [BETA_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		est_beta = v;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_acks.size() != 0 || push || awaited_reports.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	// Main sequence: reset, directed cases, then random phases at several beta values.
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_beta(10'd1023);
		// No valid sample, then a loss before any sample.
		add_item(1'b0, '0, '1, 1'b1, CWND_MAX);
		add_item(1'b1, '0, '0, 1'b0, '0);
		// Maximum spike with credit gain, then an absorbed delayed ACK.
		add_item(1'b0, '1, 16'd2, 1'b1, 20'd100);
		add_item(1'b0, 24'd1, PKTS_ONE, 1'b1, 20'd100);
		// Warm-up with small samples, then a decision sample at the maximum window.
		for (int i = 0; i < 7; i++)
			add_item(1'b0, 24'd1, 16'd3, 1'b0, 20'd5000);
		add_item(1'b0, 24'd1, '0, 1'b0, CWND_MAX);
		// Another sample at the maximum window, then a loss classed as a bit error.
		add_item(1'b0, 24'd1, PKTS_ONE, 1'b0, CWND_MAX);
		add_item(1'b1, 24'd77, PKTS_ONE, 1'b1, 20'd9);
		// Steady run returns to normal, then a bit error loss.
		for (int i = 0; i < 9; i++)
			add_item(1'b0, 24'd500, PKTS_ONE, 1'b0, 20'd1234);
		add_item(1'b1, '0, '1, 1'b1, CWND_MAX);
		wait_idle();

		write_beta(10'd0);
		add_random_episodes(200);
		wait_idle();
		write_beta(BETA_RESET);
		add_random_episodes(200);
		wait_idle();
		write_beta(BETA_W'($urandom_range(1, 1022)));
		add_random_episodes(200);
		wait_idle();
		write_beta(10'd1023);
		add_random_episodes(200);
		wait_idle();

		if (errors == 0)
			$display("[rtt_delay_monitor_loss_classifier_top] OK");
		else
			$display("[rtt_delay_monitor_loss_classifier_top] ERROR");
		$finish;
	end

	// Watchdog.
	initial begin
		#3ms;
		$display("[rtt_delay_monitor_loss_classifier_top] ERROR");
		$finish;
	end

endmodule
